// ===== sv/ipv6_route_table_lpm_assert.svh =====
// Assertion macros for the IPv6 route table.
`ifndef IPV6_ROUTE_TABLE_LPM_ASSERT_SVH
`define IPV6_ROUTE_TABLE_LPM_ASSERT_SVH
`ifndef SYNTHESIS
`define IPRT_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("route table check failed");
`define IPRT_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("route table check failed");
`else
`define IPRT_ASSERT_NOW(lbl, pre, post)
`define IPRT_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== sv/iprt_pkg.sv =====
// Shared types and constants of the IPv6 route table.
`default_nettype none
package iprt_pkg;
    localparam int ENTRIES = 16;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] REQ_LOOKUP = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_ADD    = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] SRC_ADVERT = 2'd0;
    localparam logic [1:0] SRC_STATIC = 2'd2;

    localparam logic [7:0]  MAX_LEN = 8'd128;
    localparam logic [15:0] STATIC_METRIC_RESET = 16'd10;

    typedef struct packed {
        logic [63:0] pfx_hi;
        logic [63:0] pfx_lo;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
        logic [7:0]  ad;
        logic [15:0] metric;
        logic [7:0]  iface;
        logic [1:0]  src;
        logic [7:0]  len;
        logic [31:0] expiry;
    } entry_t;

    typedef struct packed {
        logic pfx_match;
        logic expired;
        logic same_pfx;
        logic ahead;
    } cmp_t;
endpackage
`default_nettype wire

// ===== sv/iprt_ram.sv =====
// Simple dual-port RAM with registered read data.
`default_nettype none
module iprt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/iprt_cmp.sv =====
// Compares one stored route against the request held in the sequencer.
`default_nettype none
module iprt_cmp (
    input  wire iprt_pkg::entry_t key,
    input  wire logic [31:0]      now,
    input  wire iprt_pkg::entry_t ent,
    output iprt_pkg::cmp_t        res
);
    logic [127:0] mask;
    logic [127:0] diff;

    always_comb begin
        // top len bits set; a length of 128 shifts everything out
        mask = ~({128{1'b1}} >> ent.len);
        diff = {key.pfx_hi, key.pfx_lo} ^ {ent.pfx_hi, ent.pfx_lo};
        res.pfx_match = ((diff & mask) == 128'd0);
        res.expired   = (ent.expiry != 32'd0) && (now > ent.expiry);
        res.same_pfx  = (diff == 128'd0) && (ent.len == key.len);
        if (key.len != ent.len) begin
            res.ahead = key.len > ent.len;
        end else if (key.ad != ent.ad) begin
            res.ahead = key.ad < ent.ad;
        end else begin
            res.ahead = key.metric < ent.metric;
        end
    end
endmodule
`default_nettype wire

// ===== sv/ipv6_route_table_lpm.sv =====
// IPv6 route table with longest-prefix-match lookup: top level.
//
// Requests enter on the s_ channel (valid/ready) and each gives exactly one
// item on the m_ channel. The routes sit in one RAM with registered read
// data, kept sorted longest prefix first, then distance, then metric.
// A sequencer walks the RAM one entry at a time (read, then evaluate). The
// position search and the shift that opens a slot for an insert together
// pass every stored route. An add that finds no match runs the insert
// after its scan. Deleting an expired advertised route during a lookup
// moves each later route down one slot. Clear and unknown requests go
// straight to the response state.
// The block takes one request at a time; s_ready is high while idle.
// The result goes to an output register, so the next request is taken
// while a result still waits for m_ready; a stalled receiver only holds
// the sequencer once a second result is ready.
// Reset (aresetn low, synchronous) empties the table and sets the default
// static metric to 10; the RAM needs no clearing since only entries below
// the route count are ever read. cfg_wr_en writes the default metric.
`default_nettype none
`include "ipv6_route_table_lpm_assert.svh"
module ipv6_route_table_lpm (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [63:0] s_addr_hi,
    input  wire logic [63:0] s_addr_lo,
    input  wire logic [7:0]  s_prefix_len,
    input  wire logic [1:0]  s_route_source,
    input  wire logic [7:0]  s_iface_id,
    input  wire logic [63:0] s_next_hop_hi,
    input  wire logic [63:0] s_next_hop_lo,
    input  wire logic [15:0] s_metric,
    input  wire logic [7:0]  s_admin_distance,
    input  wire logic [31:0] s_expiry_tick,
    input  wire logic [31:0] s_now_tick,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_hit_iface,
    output logic [63:0]      m_hit_next_hop_hi,
    output logic [63:0]      m_hit_next_hop_lo,
    output logic [7:0]       m_hit_prefix_len,
    output logic [1:0]       m_hit_source,
    output logic [4:0]       m_entry_count
);
    localparam int IW = iprt_pkg::IW;
    localparam int CW = iprt_pkg::CW;
    localparam int EW = $bits(iprt_pkg::entry_t);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN_RD = 9'b000000010,
        S_SCAN_EV = 9'b000000100,
        S_SHDN_RD = 9'b000001000,
        S_SHDN_WR = 9'b000010000,
        S_SHUP_RD = 9'b000100000,
        S_SHUP_WR = 9'b001000000,
        S_PUT     = 9'b010000000,
        S_RESP    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [15:0]       dflt_metric_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     sj_reg, sj_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [2:0]        req_reg, req_next;
    logic [31:0]       now_reg, now_next;
    logic              ins_reg, ins_next;
    logic [1:0]        status_reg, status_next;
    iprt_pkg::entry_t  new_reg, new_next;
    iprt_pkg::entry_t  hit_reg, hit_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_load;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    iprt_pkg::entry_t  ram_wdata, rd_ent;
    logic [EW-1:0]     rd_bits;
    iprt_pkg::cmp_t    cmp;

    iprt_ram #(.DEPTH(iprt_pkg::ENTRIES), .WIDTH(EW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (EW'(ram_wdata)),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );
    assign rd_ent = iprt_pkg::entry_t'(rd_bits);

    iprt_cmp u_cmp (
        .key (new_reg),
        .now (now_reg),
        .ent (rd_ent),
        .res (cmp)
    );

    // Reads default to ptr_reg, so a write (e.g. the add update in S_SCAN_EV)
    // can hit the entry being read in the same cycle.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        sj_next     = sj_reg;
        pos_next    = pos_reg;
        req_next    = req_reg;
        now_next    = now_reg;
        ins_next    = ins_reg;
        status_next = status_reg;
        new_next    = new_reg;
        hit_next    = hit_reg;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = sj_reg[IW-1:0];
        ram_wdata   = rd_ent;
        ram_raddr   = ptr_reg[IW-1:0];
        s_ready     = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_req_type;
                    now_next        = s_now_tick;
                    ptr_next        = '0;
                    ins_next        = 1'b0;
                    new_next.pfx_hi = s_addr_hi;
                    new_next.pfx_lo = s_addr_lo;
                    new_next.len    = (s_prefix_len > iprt_pkg::MAX_LEN) ?
                                      iprt_pkg::MAX_LEN : s_prefix_len;
                    new_next.src    = s_route_source;
                    new_next.iface  = s_iface_id;
                    new_next.expiry = s_expiry_tick;
                    if (s_req_type == iprt_pkg::REQ_ADD) begin
                        new_next.hop_hi = '0;
                        new_next.hop_lo = '0;
                        new_next.metric = '0;
                        new_next.ad     = '0;
                    end else begin
                        new_next.hop_hi = s_next_hop_hi;
                        new_next.hop_lo = s_next_hop_lo;
                        new_next.ad     = s_admin_distance;
                        new_next.metric = (s_route_source == iprt_pkg::SRC_STATIC &&
                                           s_metric == 16'd0) ? dflt_metric_reg : s_metric;
                    end
                    case (s_req_type)
                        iprt_pkg::REQ_LOOKUP, iprt_pkg::REQ_REMOVE: begin
                            status_next = iprt_pkg::ST_MISS;
                            state_next  = S_SCAN_RD;
                        end
                        iprt_pkg::REQ_ADD: begin
                            status_next = iprt_pkg::ST_OK;
                            state_next  = S_SCAN_RD;
                        end
                        iprt_pkg::REQ_INSERT: begin
                            if (count_reg >= CW'(iprt_pkg::ENTRIES)) begin
                                status_next = iprt_pkg::ST_FULL;
                                state_next  = S_RESP;
                            end else begin
                                status_next = iprt_pkg::ST_OK;
                                ins_next    = 1'b1;
                                state_next  = S_SCAN_RD;
                            end
                        end
                        iprt_pkg::REQ_CLEAR: begin
                            count_next  = '0;
                            status_next = iprt_pkg::ST_OK;
                            state_next  = S_RESP;
                        end
                        default: begin
                            status_next = iprt_pkg::ST_OK;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (ptr_reg == count_reg) begin
                    if (ins_reg) begin
                        pos_next   = ptr_reg;
                        sj_next    = count_reg;
                        state_next = S_SHUP_RD;
                    end else if (req_reg == iprt_pkg::REQ_ADD) begin
                        if (count_reg >= CW'(iprt_pkg::ENTRIES)) begin
                            status_next = iprt_pkg::ST_FULL;
                            state_next  = S_RESP;
                        end else begin
                            // no match: second pass finds the insert position
                            ins_next = 1'b1;
                            ptr_next = '0;
                        end
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                state_next = S_SCAN_RD;
                ptr_next   = ptr_reg + CW'(1);
                if (ins_reg) begin
                    if (cmp.ahead) begin
                        ptr_next   = ptr_reg;
                        pos_next   = ptr_reg;
                        sj_next    = count_reg;
                        state_next = S_SHUP_RD;
                    end
                end else begin
                    case (req_reg)
                        iprt_pkg::REQ_LOOKUP: begin
                            if (cmp.pfx_match) begin
                                if (!cmp.expired) begin
                                    hit_next    = rd_ent;
                                    status_next = iprt_pkg::ST_OK;
                                    state_next  = S_RESP;
                                end else if (rd_ent.src == iprt_pkg::SRC_ADVERT) begin
                                    ptr_next   = ptr_reg;
                                    sj_next    = ptr_reg;
                                    state_next = S_SHDN_RD;
                                end
                            end
                        end
                        iprt_pkg::REQ_REMOVE: begin
                            if (cmp.same_pfx && rd_ent.src == iprt_pkg::SRC_ADVERT) begin
                                status_next = iprt_pkg::ST_OK;
                                sj_next     = ptr_reg;
                                state_next  = S_SHDN_RD;
                            end
                        end
                        iprt_pkg::REQ_ADD: begin
                            if (cmp.same_pfx && rd_ent.src == new_reg.src) begin
                                ram_we           = 1'b1;
                                ram_waddr        = ptr_reg[IW-1:0];
                                ram_wdata        = rd_ent;
                                ram_wdata.iface  = new_reg.iface;
                                ram_wdata.expiry = new_reg.expiry;
                                state_next       = S_RESP;
                            end
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_SHDN_RD: begin
                if (sj_reg + CW'(1) >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = (req_reg == iprt_pkg::REQ_LOOKUP) ? S_SCAN_RD : S_RESP;
                end else begin
                    ram_raddr  = IW'(sj_reg + CW'(1));
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                ram_we     = 1'b1;
                sj_next    = sj_reg + CW'(1);
                state_next = S_SHDN_RD;
            end
            S_SHUP_RD: begin
                if (sj_reg == pos_reg) begin
                    state_next = S_PUT;
                end else begin
                    ram_raddr  = IW'(sj_reg - CW'(1));
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR: begin
                ram_we     = 1'b1;
                sj_next    = sj_reg - CW'(1);
                state_next = S_SHUP_RD;
            end
            S_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[IW-1:0];
                ram_wdata  = new_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
            dflt_metric_reg <= iprt_pkg::STATIC_METRIC_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                dflt_metric_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        sj_reg     <= sj_next;
        pos_reg    <= pos_next;
        req_reg    <= req_next;
        now_reg    <= now_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        new_reg    <= new_next;
        hit_reg    <= hit_next;
        if (out_load) begin
            m_status      <= status_reg;
            m_entry_count <= 5'(count_reg);
            if (req_reg == iprt_pkg::REQ_LOOKUP && status_reg == iprt_pkg::ST_OK) begin
                m_hit_iface       <= hit_reg.iface;
                m_hit_next_hop_hi <= hit_reg.hop_hi;
                m_hit_next_hop_lo <= hit_reg.hop_lo;
                m_hit_prefix_len  <= hit_reg.len;
                m_hit_source      <= hit_reg.src;
            end else begin
                m_hit_iface       <= '0;
                m_hit_next_hop_hi <= '0;
                m_hit_next_hop_lo <= '0;
                m_hit_prefix_len  <= '0;
                m_hit_source      <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    `IPRT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(iprt_pkg::ENTRIES))
    `IPRT_ASSERT_NXT(a_put_grows, state_reg == S_PUT, count_reg == $past(count_reg) + CW'(1))
    `IPRT_ASSERT_NOW(a_shift_bound, state_reg == S_SHUP_WR, sj_reg <= count_reg && sj_reg > pos_reg)
    `IPRT_ASSERT_NXT(a_resp_loads, state_reg == S_RESP && (!m_valid_reg || m_ready), m_valid_reg)
endmodule
`default_nettype wire
